[src/sis_pkg.sv]
package sis_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_POP    = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_error;

    typedef struct packed {
        logic                     push;
        logic                     insert;
        logic                     pop;
        logic                     clear;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

[src/sis_cell.sv]
module sis_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sis_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_below_occ,
    input  logic                              i_below_lt,
    input  logic signed [sis_pkg::DATA_W-1:0] i_below_data,
    input  logic                              i_above_occ,
    input  logic                              i_above_any_lt,
    output logic                              o_occ,
    output logic                              o_lt,
    output logic                              o_any_lt,
    output logic signed [sis_pkg::DATA_W-1:0] o_data,
    output logic signed [sis_pkg::DATA_W-1:0] o_top_data
);

    logic                              r_occ;
    logic                              n_occ;
    logic signed [sis_pkg::DATA_W-1:0] r_data;
    logic signed [sis_pkg::DATA_W-1:0] n_data;
    logic                              lt;
    logic                              any_lt;

    assign lt     = r_occ & (r_data < i_ctl.value);
    assign any_lt = lt | i_above_any_lt;

    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        if (i_ctl.clear) begin
            n_occ = 1'b0;
        end else if (i_ctl.pop) begin
            n_occ = i_above_occ;
        end else if (i_ctl.push) begin
            n_occ = r_occ | i_below_occ;
            if (!r_occ && i_below_occ) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.insert) begin
            n_occ = r_occ | i_below_occ;
            if (!any_lt) begin
                if (i_below_lt) begin
                    n_data = i_ctl.value;
                end else if (i_below_occ) begin
                    n_data = i_below_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_occ      = r_occ;
    assign o_lt       = lt;
    assign o_any_lt   = any_lt;
    assign o_data     = r_data;
    assign o_top_data = (r_occ && !i_above_occ) ? r_data : '0;

endmodule

[src/sorted_insert_stack_top.sv]
// Bounded stack of signed 32-bit words with plain push, sorted insert, pop
// and clear.
// A command word (i_action, i_value) is taken at a rising edge where start
// is high and busy is low; busy is always low, so a word may be given in
// every cycle. The result word appears on the o_ ports in the following
// cycle, marked by o_valid for exactly one cycle; throughput one word per
// cycle.
// Every entry sits in a cell of a chain; a sorted insert is settled in the
// same cycle by a per-cell compare and a flag rippling down from the top,
// and the cells below the insertion point stay put while those above it
// take their lower neighbour's entry.
// A push or insert on a full stack is dropped with error 1, a pop on an
// empty stack returns zero with error 2.
// Synchronous reset empties the stack and drops any pending result; the
// stored entries themselves are not cleared. The receiver cannot stall the
// block and must take each result in the cycle it is shown.
module sorted_insert_stack_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_action,
    input  logic signed [sis_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    output logic signed [sis_pkg::DATA_W-1:0] o_popped_value,
    output logic signed [sis_pkg::DATA_W-1:0] o_top_value,
    output logic [sis_pkg::CNT_W-1:0]         o_count,
    output logic                              o_empty_res,
    output logic [1:0]                        o_error
);

    localparam int D = sis_pkg::DEPTH;
    localparam int W = sis_pkg::DATA_W;
    localparam int C = sis_pkg::CNT_W;

    logic                r_valid;
    logic                n_valid;
    logic [C-1:0]        r_count;
    logic [C-1:0]        n_count;
    logic signed [W-1:0] r_popped;
    logic signed [W-1:0] n_popped;
    sis_pkg::t_error     r_error;
    sis_pkg::t_error     n_error;

    sis_pkg::t_cell_ctl  ctl;
    logic                accept;
    logic                full;
    logic                empty;
    logic signed [W-1:0] top_now;

    logic                occ    [D];
    logic                lt     [D];
    logic                any_lt [D];
    logic signed [W-1:0] data   [D];
    logic signed [W-1:0] top_d  [D];

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign full   = (r_count == C'(D));
    assign empty  = (r_count == '0);

    always_comb begin
        top_now = '0;
        for (int k = 0; k < D; k++) begin
            top_now = top_now | top_d[k];
        end
    end

    always_comb begin
        ctl        = '0;
        ctl.value  = i_value;
        n_valid    = accept;
        n_count    = r_count;
        n_popped   = '0;
        n_error    = sis_pkg::ERR_NONE;
        if (accept) begin
            case (sis_pkg::t_action'(i_action))
                sis_pkg::ACT_PUSH: begin
                    if (full) begin
                        n_error = sis_pkg::ERR_FULL;
                    end else begin
                        ctl.push = 1'b1;
                        n_count  = r_count + C'(1);
                    end
                end
                sis_pkg::ACT_INSERT: begin
                    if (full) begin
                        n_error = sis_pkg::ERR_FULL;
                    end else begin
                        ctl.insert = 1'b1;
                        n_count    = r_count + C'(1);
                    end
                end
                sis_pkg::ACT_POP: begin
                    if (empty) begin
                        n_error = sis_pkg::ERR_EMPTY;
                    end else begin
                        ctl.pop  = 1'b1;
                        n_count  = r_count - C'(1);
                        n_popped = top_now;
                    end
                end
                sis_pkg::ACT_CLEAR: begin
                    ctl.clear = 1'b1;
                    n_count   = '0;
                end
                default: begin
                    n_error = sis_pkg::ERR_NONE;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            logic                b_occ;
            logic                b_lt;
            logic signed [W-1:0] b_data;
            logic                a_occ;
            logic                a_any_lt;

            if (g == 0) begin : g_bottom
                assign b_occ  = 1'b1;
                assign b_lt   = 1'b1;
                assign b_data = '0;
            end else begin : g_mid_low
                assign b_occ  = occ[g-1];
                assign b_lt   = lt[g-1];
                assign b_data = data[g-1];
            end

            if (g == D - 1) begin : g_top
                assign a_occ    = 1'b0;
                assign a_any_lt = 1'b0;
            end else begin : g_mid_high
                assign a_occ    = occ[g+1];
                assign a_any_lt = any_lt[g+1];
            end

            sis_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (ctl),
                .i_below_occ    (b_occ),
                .i_below_lt     (b_lt),
                .i_below_data   (b_data),
                .i_above_occ    (a_occ),
                .i_above_any_lt (a_any_lt),
                .o_occ          (occ[g]),
                .o_lt           (lt[g]),
                .o_any_lt       (any_lt[g]),
                .o_data         (data[g]),
                .o_top_data     (top_d[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_error <= sis_pkg::ERR_NONE;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_error <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
    end

    assign o_valid        = r_valid;
    assign o_popped_value = r_popped;
    assign o_top_value    = top_now;
    assign o_count        = r_count;
    assign o_empty_res    = (r_count == '0);
    assign o_error        = r_error;

endmodule

[src/sis_chk.sv]
module sis_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [sis_pkg::DATA_W-1:0] o_popped_value,
    input logic signed [sis_pkg::DATA_W-1:0] o_top_value,
    input logic [sis_pkg::CNT_W-1:0]         o_count,
    input logic                              o_empty_res,
    input logic [1:0]                        o_error
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted word gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without an accepted word");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_empty_res == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_res) |-> (o_top_value == '0))
        else $error("empty stack shows a top word");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error == sis_pkg::ERR_EMPTY) |->
            (o_popped_value == '0 && o_count == '0))
        else $error("failed pop returned data");

endmodule

bind sorted_insert_stack_top sis_chk u_sis_chk (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sis_pkg::*;

    localparam int N_RANDOM   = 1875;
    localparam int MAX_CYCLES = 400000;

    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh80000000;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic signed [DATA_W-1:0] top;
        logic [CNT_W-1:0]         count;
        logic                     empty;
        logic [1:0]               err;
    } t_outcome;

    typedef struct {
        t_action                  act;
        logic signed [DATA_W-1:0] val;
        bit                       fixed;
        t_outcome                 want;
    } t_cmd;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     start    = 1'b0;
    logic                     busy;
    logic [1:0]               i_action = ACT_PUSH;
    logic signed [DATA_W-1:0] i_value  = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_popped_value;
    logic signed [DATA_W-1:0] o_top_value;
    logic [CNT_W-1:0]         o_count;
    logic                     o_empty_res;
    logic [1:0]               o_error;

    bit       cmd_fixed = 1'b0;
    t_outcome cmd_want  = '0;

    logic signed [DATA_W-1:0] shadow_stack [DEPTH];
    int                       shadow_fill = 0;
    t_outcome                 outcomes_due [$];
    t_cmd                     script [$];

    int mismatches    = 0;
    int cycle_cnt     = 0;
    int words_taken   = 0;
    int results_seen  = 0;
    int full_rejects  = 0;
    int empty_pops    = 0;
    int deepest_fill  = 0;

    sorted_insert_stack_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_count        (o_count),
        .o_empty_res    (o_empty_res),
        .o_error        (o_error)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_cnt, outcomes_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Applies one command word to the shadow stack and returns the result word it causes.
    function automatic t_outcome stack_step(t_action act, logic signed [DATA_W-1:0] val);
        t_outcome res;
        int       n;
        int       pos;
        res = '0;
        n   = shadow_fill;
        case (act)
            ACT_PUSH, ACT_INSERT: begin
                if (n >= DEPTH) begin
                    res.err = ERR_FULL;
                end else begin
                    pos = n;
                    if (act == ACT_INSERT) begin
                        while (pos > 0 && shadow_stack[pos-1] >= val)
                            pos--;
                    end
                    for (int i = n; i > pos; i--)
                        shadow_stack[i] = shadow_stack[i-1];
                    shadow_stack[pos] = val;
                    n++;
                end
            end
            ACT_POP: begin
                if (n == 0) begin
                    res.err = ERR_EMPTY;
                end else begin
                    n--;
                    res.popped = shadow_stack[n];
                end
            end
            default: begin
                n = 0;
            end
        endcase
        shadow_fill = n;
        res.top     = (n > 0) ? shadow_stack[n-1] : '0;
        res.count   = CNT_W'(n);
        res.empty   = (n == 0);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("Mismatch at %0t on %s: got %0h, expected %0h.", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_word(t_outcome w);
        if (o_popped_value !== w.popped)
            report_mismatch("popped_value", o_popped_value, w.popped);
        if (o_top_value !== w.top)
            report_mismatch("top_value", o_top_value, w.top);
        if (o_count !== w.count)
            report_mismatch("count", DATA_W'(o_count), DATA_W'(w.count));
        if (o_empty_res !== w.empty)
            report_mismatch("empty_res", DATA_W'(o_empty_res), DATA_W'(w.empty));
        if (o_error !== w.err)
            report_mismatch("error", DATA_W'(o_error), DATA_W'(w.err));
    endtask

    always @(posedge i_clk) begin
        t_outcome predicted;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                results_seen++;
                if (outcomes_due.size() == 0)
                    report_mismatch("result word with none outstanding", o_top_value, '0);
                else
                    check_word(outcomes_due.pop_front());
            end
            if (start && busy === 1'b0) begin
                predicted = stack_step(t_action'(i_action), i_value);
                outcomes_due.push_back(cmd_fixed ? cmd_want : predicted);
                words_taken++;
                if (predicted.err == ERR_FULL)
                    full_rejects++;
                if (predicted.err == ERR_EMPTY)
                    empty_pops++;
                if (shadow_fill > deepest_fill)
                    deepest_fill = shadow_fill;
            end
        end
    end

    function automatic t_cmd plain(t_action act, logic signed [DATA_W-1:0] val);
        t_cmd c;
        c.act   = act;
        c.val   = val;
        c.fixed = 1'b0;
        c.want  = '0;
        return c;
    endfunction

    function automatic t_cmd fixed(t_action act, logic signed [DATA_W-1:0] val,
                                   logic signed [DATA_W-1:0] popped,
                                   logic signed [DATA_W-1:0] top, int cnt, t_error err);
        t_cmd c;
        c = plain(act, val);
        c.fixed       = 1'b1;
        c.want.popped = popped;
        c.want.top    = top;
        c.want.count  = CNT_W'(cnt);
        c.want.empty  = (cnt == 0);
        c.want.err    = err;
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'($signed($urandom_range(0, 16)) - 8);
            4: begin
                case ($urandom_range(0, 3))
                    0: return MAX_VAL;
                    1: return MIN_VAL;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_action pick_action(int mode, int k, int len);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (r < 2) return ACT_CLEAR;
                if (r < 45) return ACT_PUSH;
                if (r < 85) return ACT_INSERT;
                return ACT_POP;
            end
            1: begin
                if (r < 2) return ACT_CLEAR;
                if (r < 15) return ACT_PUSH;
                if (r < 30) return ACT_INSERT;
                return ACT_POP;
            end
            2: return (k < len / 2) ? ACT_INSERT : ACT_POP;
            default: begin
                if (r < 6) return ACT_CLEAR;
                case ($urandom_range(0, 2))
                    0: return ACT_PUSH;
                    1: return ACT_INSERT;
                    default: return ACT_POP;
                endcase
            end
        endcase
    endfunction

    function automatic int next_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(t_cmd c, int gap);
        start     <= 1'b1;
        i_action  <= c.act;
        i_value   <= c.val;
        cmd_fixed <= c.fixed;
        cmd_want  <= c.want;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_cmd c;
        int   sent;
        int   mode;
        int   len;
        bit   quiet;

        script.push_back(fixed(ACT_POP,    '0,            '0,      '0,      0, ERR_EMPTY));
        script.push_back(fixed(ACT_PUSH,   MAX_VAL,       '0,      MAX_VAL, 1, ERR_NONE));
        script.push_back(fixed(ACT_PUSH,   MIN_VAL,       '0,      MIN_VAL, 2, ERR_NONE));
        script.push_back(fixed(ACT_POP,    '1,            MIN_VAL, MAX_VAL, 1, ERR_NONE));
        script.push_back(fixed(ACT_CLEAR,  32'sh5A5A5A5A, '0,      '0,      0, ERR_NONE));
        script.push_back(plain(ACT_INSERT, 32'sd5));
        script.push_back(plain(ACT_INSERT, 32'sd5));
        script.push_back(plain(ACT_INSERT, -32'sd3));
        script.push_back(plain(ACT_INSERT, 32'sd10));
        script.push_back(plain(ACT_INSERT, 32'sd0));
        script.push_back(plain(ACT_INSERT, MAX_VAL));
        script.push_back(plain(ACT_INSERT, MIN_VAL));
        script.push_back(plain(ACT_INSERT, 32'sd5));
        script.push_back(plain(ACT_PUSH,   '1));
        script.push_back(plain(ACT_PUSH,   32'sh55555555));
        script.push_back(plain(ACT_PUSH,   32'shAAAAAAAA));
        script.push_back(plain(ACT_INSERT, 32'sd7));
        script.push_back(plain(ACT_PUSH,   32'sd1));
        script.push_back(plain(ACT_PUSH,   32'sd0));
        script.push_back(plain(ACT_INSERT, -32'sd3));
        script.push_back(plain(ACT_PUSH,   32'sh12345678));
        script.push_back(fixed(ACT_PUSH,   32'sd99,  '0, 32'sh12345678, 16, ERR_FULL));
        script.push_back(fixed(ACT_INSERT, MIN_VAL,  '0, 32'sh12345678, 16, ERR_FULL));
        script.push_back(fixed(ACT_CLEAR,  '0,       '0, '0,             0, ERR_NONE));
        script.push_back(fixed(ACT_POP,    MAX_VAL,  '0, '0,             0, ERR_EMPTY));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            send_word(script[i], next_gap(i < 12));

        sent = 0;
        while (sent < N_RANDOM) begin
            mode  = $urandom_range(0, 3);
            quiet = ($urandom_range(0, 3) == 0);
            len   = $urandom_range(8, 60);
            for (int k = 0; k < len && sent < N_RANDOM; k++) begin
                c = plain(pick_action(mode, k, len), rand_value());
                send_word(c, next_gap(quiet));
                sent++;
            end
        end
        start <= 1'b0;

        while (outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d command words (%0d from the directed table), checked %0d results.",
                 words_taken, script.size(), results_seen);
        $display("Rejected pushes on full: %0d, pops on empty: %0d, deepest fill: %0d of %0d.",
                 full_rejects, empty_pops, deepest_fill, DEPTH);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
